// File: design/tgpm_pkg.sv
// ----------------------------------------------------------------------------
// tgpm_pkg
// Shared constants and types for the tint / gradient pixel map pipeline.
// ----------------------------------------------------------------------------
package tgpm_pkg;

    // Level and scale constants
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned COLOR_W    = 24;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam logic [7:0]  LEVEL_MAX  = 8'd255;
    localparam logic [7:0]  LEVEL_HALF = 8'd127;
    localparam logic [8:0]  LEVEL_MID  = 9'd128;
    localparam logic [15:0] SQ_SCALE   = 16'd65025;

    // floor(2^32 / 65025): estimate is exact or one low
    localparam logic [16:0] TINT_RECIP = 17'd66051;
    // 257 / 2^16 approximates 1/255 from below
    localparam logic [8:0]  BYTE_RECIP = 9'd257;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_LEVEL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_LOW   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_MID   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_HIGH  = 8'd3;

    // Register reset values
    localparam logic [7:0]         RST_TINT_LEVEL = 8'd0;
    localparam logic [COLOR_W-1:0] RST_GRAD_LOW   = 24'd0;
    localparam logic [COLOR_W-1:0] RST_GRAD_MID   = 24'd255;
    localparam logic [COLOR_W-1:0] RST_GRAD_HIGH  = 24'd65535;

    // Pipeline latency from accepted request to result strobe
    localparam int unsigned LATENCY = 8;

    // Gradient colours
    typedef struct packed {
        logic [COLOR_W-1:0] low;
        logic [COLOR_W-1:0] mid;
        logic [COLOR_W-1:0] high;
    } t_grad_cfg;

    // Tinted level handed from the tint stage to the blend stage
    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
    } t_level_req;

endpackage

// File: design/tint_gradient_pixel_map.sv
// ----------------------------------------------------------------------------
// tint_gradient_pixel_map
// Per-pixel tint and three-colour gradient map.
// ----------------------------------------------------------------------------
// One pixel request per clock: a request is taken whenever start is high and
// busy is low, and busy is low at all times outside reset. Each result
// appears on the o_out_ch* ports with o_valid high for exactly one cycle,
// in request order; the receiver cannot stall, so nothing holds the
// pipeline. Each request passes through the five-stage tint pipeline (square,
// weight multiply, sum, reciprocal multiply, correction) and then the
// three-stage blend (weighted sums, reciprocal multiply, correction).
// Registers are written through the cfg channel, which is always ready
// outside reset; write them only while no request is in flight.
module tint_gradient_pixel_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_pixel_level,
    output logic        o_valid,
    output logic [7:0]  o_out_ch0,
    output logic [7:0]  o_out_ch1,
    output logic [7:0]  o_out_ch2,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [tgpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tgpm_pkg::COLOR_W-1:0]   i_cfg_data
);

    logic                 req_acc;
    logic [7:0]           r_tint;
    tgpm_pkg::t_grad_cfg  r_grad;
    tgpm_pkg::t_level_req tint_req;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign req_acc     = start & ~busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint      <= tgpm_pkg::RST_TINT_LEVEL;
            r_grad.low  <= tgpm_pkg::RST_GRAD_LOW;
            r_grad.mid  <= tgpm_pkg::RST_GRAD_MID;
            r_grad.high <= tgpm_pkg::RST_GRAD_HIGH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tgpm_pkg::CFG_TINT_LEVEL: r_tint      <= i_cfg_data[7:0];
                tgpm_pkg::CFG_GRAD_LOW:   r_grad.low  <= i_cfg_data;
                tgpm_pkg::CFG_GRAD_MID:   r_grad.mid  <= i_cfg_data;
                tgpm_pkg::CFG_GRAD_HIGH:  r_grad.high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tgpm_tint u_tint (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_acc),
        .i_level (i_pixel_level),
        .i_tint  (r_tint),
        .o_req   (tint_req)
    );

    tgpm_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tint_req),
        .i_grad  (r_grad),
        .o_valid (o_valid),
        .o_ch0   (o_out_ch0),
        .o_ch1   (o_out_ch1),
        .o_ch2   (o_out_ch2)
    );

endmodule

// File: design/tgpm_tint.sv
// ----------------------------------------------------------------------------
// tgpm_tint
// Five-stage tint pipeline: t = clamp(trunc((g*65025 + w*(c-g)) / 65025)),
// w = 65025 - 4*(g-128)^2.
// ----------------------------------------------------------------------------
module tgpm_tint (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [tgpm_pkg::LEVEL_W-1:0] i_level,
    input  logic [tgpm_pkg::LEVEL_W-1:0] i_tint,
    output tgpm_pkg::t_level_req       o_req
);

    // Valid bits for each stage
    logic [4:0] r_vld;

    // Stage 1: square of offset from mid-gray, distance to tint
    logic signed [8:0]  d1;
    logic signed [17:0] dsq_full;
    logic [7:0]         r_g1;
    logic [14:0]        r_dsq1;
    logic signed [8:0]  r_diff1;

    assign d1       = $signed({1'b0, i_level}) - $signed(tgpm_pkg::LEVEL_MID);
    assign dsq_full = d1 * d1;

    always_ff @(posedge i_clk) begin
        r_g1    <= i_level;
        r_dsq1  <= dsq_full[14:0];
        r_diff1 <= $signed({1'b0, i_tint}) - $signed({1'b0, i_level});
    end

    // Stage 2: weight times distance, scaled gray level
    logic signed [17:0] w2;
    logic signed [26:0] r_prod2;
    logic [23:0]        r_gsc2;

    assign w2 = $signed({2'b00, tgpm_pkg::SQ_SCALE}) - $signed({1'b0, r_dsq1, 2'b00});

    always_ff @(posedge i_clk) begin
        r_prod2 <= 27'(w2 * r_diff1);
        r_gsc2  <= 24'(r_g1 * tgpm_pkg::SQ_SCALE);
    end

    // Stage 3: numerator
    logic signed [26:0] r_num3;

    always_ff @(posedge i_clk) begin
        r_num3 <= $signed({3'b000, r_gsc2}) + r_prod2;
    end

    // Stage 4: reciprocal estimate of the quotient
    logic [42:0] qprod4;
    logic [9:0]  r_q4;
    logic [25:0] r_mag4;
    logic        r_neg4;

    assign qprod4 = 43'(r_num3[25:0] * tgpm_pkg::TINT_RECIP);

    always_ff @(posedge i_clk) begin
        r_q4   <= qprod4[41:32];
        r_mag4 <= r_num3[25:0];
        r_neg4 <= r_num3[26];
    end

    // Stage 5: correct the estimate, saturate
    logic [25:0] rem5;
    logic [9:0]  q5;
    logic [7:0]  t5;
    logic [7:0]  r_t5;

    always_comb begin
        rem5 = r_mag4 - 26'(r_q4 * tgpm_pkg::SQ_SCALE);
        q5   = r_q4 + 10'(rem5 >= 26'(tgpm_pkg::SQ_SCALE));
        if (r_neg4) begin
            t5 = '0;
        end else if (q5 > 10'(tgpm_pkg::LEVEL_MAX)) begin
            t5 = tgpm_pkg::LEVEL_MAX;
        end else begin
            t5 = q5[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_t5 <= t5;
    end

    // Valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    assign o_req.valid = r_vld[4];
    assign o_req.level = r_t5;

endmodule

// File: design/tgpm_blend.sv
// ----------------------------------------------------------------------------
// tgpm_blend
// Three-stage gradient blend: pick colour pair by level, weight each channel,
// divide by 255.
// ----------------------------------------------------------------------------
module tgpm_blend (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tgpm_pkg::t_level_req i_req,
    input  tgpm_pkg::t_grad_cfg  i_grad,
    output logic                 o_valid,
    output logic [7:0]           o_ch0,
    output logic [7:0]           o_ch1,
    output logic [7:0]           o_ch2
);

    logic [2:0] r_vld;

    // Stage 6: colour pair, weight, weighted sums
    logic [23:0] lower6;
    logic [23:0] upper6;
    logic [8:0]  r2x;
    logic [7:0]  r6;
    logic [7:0]  rinv6;
    logic [15:0] r_sum6 [3];

    always_comb begin
        r2x = {i_req.level, 1'b0};
        if (i_req.level <= tgpm_pkg::LEVEL_HALF) begin
            lower6 = i_grad.low;
            upper6 = i_grad.mid;
            r6     = r2x[7:0];
        end else begin
            lower6 = i_grad.mid;
            upper6 = i_grad.high;
            r6     = 8'(r2x - 9'(tgpm_pkg::LEVEL_MAX));
        end
        rinv6 = tgpm_pkg::LEVEL_MAX - r6;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_sum6[k] <= 16'(rinv6 * lower6[8*k +: 8]) + 16'(r6 * upper6[8*k +: 8]);
        end
    end

    // Stage 7: quotient estimate (exact or one low)
    logic [7:0]  r_q7   [3];
    logic [15:0] r_sum7 [3];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_q7[k]   <= 8'((25'(r_sum6[k] * tgpm_pkg::BYTE_RECIP)) >> 16);
            r_sum7[k] <= r_sum6[k];
        end
    end

    // Stage 8: correction into output registers
    logic [15:0] rem8 [3];
    logic [7:0]  q8   [3];
    logic [7:0]  r_out [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rem8[k] = r_sum7[k] - 16'(r_q7[k] * tgpm_pkg::LEVEL_MAX);
            q8[k]   = r_q7[k] + 8'(rem8[k] >= 16'(tgpm_pkg::LEVEL_MAX));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_out[k] <= q8[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_req.valid};
        end
    end

    assign o_valid = r_vld[2];
    assign o_ch0   = r_out[0];
    assign o_ch1   = r_out[1];
    assign o_ch2   = r_out[2];

endmodule

// File: design/tgpm_checker.sv
// ----------------------------------------------------------------------------
// tgpm_checker
// Port-level checks on request to result timing of the pixel map.
// ----------------------------------------------------------------------------
module tgpm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_cfg_ready
);

    // Every accepted request yields a result after the fixed latency
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##8 o_valid)
        else $error("request produced no result after pipeline latency");

    // No result without a request the fixed latency earlier
    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 8))
        else $error("result strobe without matching request");

    // Reset empties the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // Request and config sides open together once out of reset
    a_ready_align: assert property (@(posedge i_clk)
        busy != o_cfg_ready)
        else $error("busy and config ready disagree");

endmodule

bind tint_gradient_pixel_map tgpm_checker u_tgpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_cfg_ready (o_cfg_ready)
);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: tint_gradient_pixel_map testbench
// Streams pixel requests in random bursts under several register settings and
// checks every mapped pixel against an in-bench tint and gradient predictor.
// ----------------------------------------------------------------------------
module tb;
    import tgpm_pkg::*;

    localparam int unsigned PIXEL_TARGET = 1900;
    localparam int unsigned STUCK_LIMIT  = 4000;
    localparam int unsigned PRINT_CAP    = 30;

    // One mapped output pixel
    typedef struct packed {
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
    } t_mapped_px;

    // Predicts each mapped pixel and checks results in request order
    class pixel_map_scoreboard;
        logic [7:0]         tint_lvl;
        logic [COLOR_W-1:0] col_low;
        logic [COLOR_W-1:0] col_mid;
        logic [COLOR_W-1:0] col_high;
        t_mapped_px         expected_px[$];
        int                 errors;

        function new();
            tint_lvl = RST_TINT_LEVEL;
            col_low  = RST_GRAD_LOW;
            col_mid  = RST_GRAD_MID;
            col_high = RST_GRAD_HIGH;
            errors   = 0;
        endfunction

        function int pending();
            return expected_px.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
            case (idx)
                CFG_TINT_LEVEL: tint_lvl = data[7:0];
                CFG_GRAD_LOW:   col_low  = data;
                CFG_GRAD_MID:   col_mid  = data;
                CFG_GRAD_HIGH:  col_high = data;
                default: ;  // unknown index: dropped
            endcase
        endfunction

        // Tint pull toward tint_lvl, then blend on the matching gradient half
        function t_mapped_px map_pixel(logic [7:0] g);
            longint             dev, wgt, num, lvl;
            int unsigned        ratio, k, v;
            logic [COLOR_W-1:0] lower, upper;
            logic [7:0]         chan[3];
            t_mapped_px         px;
            dev = longint'(g) - 128;
            wgt = 65025 - 4 * dev * dev;
            num = longint'(g) * 65025 + wgt * (longint'(tint_lvl) - longint'(g));
            lvl = num / 65025;  // truncates toward zero
            if (lvl < 0)
                lvl = 0;
            if (lvl > 255)
                lvl = 255;
            if (lvl <= 127) begin
                lower = col_low;
                upper = col_mid;
                ratio = 32'(2 * lvl);
            end else begin
                lower = col_mid;
                upper = col_high;
                ratio = 32'(2 * lvl - 255);
            end
            for (k = 0; k < 3; k++) begin
                v = ((255 - ratio) * lower[8*k +: 8] + ratio * upper[8*k +: 8]) / 255;
                chan[k] = v[7:0];
            end
            px.ch0 = chan[0];
            px.ch1 = chan[1];
            px.ch2 = chan[2];
            return px;
        endfunction

        function void note_pixel(logic [7:0] g);
            expected_px.push_back(map_pixel(g));
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_result(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
            t_mapped_px want;
            if (expected_px.size() == 0) begin
                report($sformatf("result %h %h %h with no request outstanding", c0, c1, c2));
                return;
            end
            want = expected_px.pop_front();
            if (c0 !== want.ch0)
                report($sformatf("ch0 got %h want %h", c0, want.ch0));
            if (c1 !== want.ch1)
                report($sformatf("ch1 got %h want %h", c1, want.ch1));
            if (c2 !== want.ch2)
                report($sformatf("ch2 got %h want %h", c2, want.ch2));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [7:0]           i_pixel_level;
    logic                 o_valid;
    logic [7:0]           o_out_ch0;
    logic [7:0]           o_out_ch1;
    logic [7:0]           o_out_ch2;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COLOR_W-1:0]   i_cfg_data;

    pixel_map_scoreboard  sb = new();
    int unsigned          pixels_sent;
    int unsigned          stuck_cycles;

    tint_gradient_pixel_map DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_pixel_level (i_pixel_level),
        .o_valid       (o_valid),
        .o_out_ch0     (o_out_ch0),
        .o_out_ch1     (o_out_ch1),
        .o_out_ch2     (o_out_ch2),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 12-unit clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Monitor: note accepted requests and register writes, check results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (start && !busy)
                sb.note_pixel(i_pixel_level);
            if (o_valid)
                sb.check_result(o_out_ch0, o_out_ch1, o_out_ch2);
        end
    end

    // Watchdog: no request, result or write accepted for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", sb.pending());
            $display("tint_gradient_pixel_map verification failed");
            $finish;
        end
    end

    // Leaves start high so back-to-back requests need no second assignment
    task send_pixel(input logic [7:0] g);
        start         <= 1'b1;
        i_pixel_level <= g;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pixels_sent++;
    endtask

    task pause(input int unsigned n);
        start         <= 1'b0;
        i_pixel_level <= 8'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    // Leaves valid high; cfg_release ends a group of writes
    task cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    task cfg_release();
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_IDX_W'($urandom);
        i_cfg_data  <= COLOR_W'($urandom);
    endtask

    // Stop requests and wait for every outstanding result
    task drain();
        pause(1);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_level();
        logic [7:0] corners[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        if ($urandom_range(0, 7) == 0)
            return corners[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    function logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    // Tint data carries random upper bits that the block must drop
    function logic [COLOR_W-1:0] pick_tint();
        logic [COLOR_W-1:0] data;
        data = COLOR_W'($urandom);
        case ($urandom_range(0, 4))
            0:       data[7:0] = 8'd0;
            1:       data[7:0] = 8'd255;
            default: ;
        endcase
        return data;
    endfunction

    task random_settings();
        if ($urandom_range(0, 1))
            cfg_write(CFG_TINT_LEVEL, pick_tint());
        if ($urandom_range(0, 1))
            cfg_write(CFG_GRAD_LOW, pick_color());
        if ($urandom_range(0, 1))
            cfg_write(CFG_GRAD_MID, pick_color());
        if ($urandom_range(0, 1))
            cfg_write(CFG_GRAD_HIGH, pick_color());
        // unknown index now and then
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(CFG_GRAD_HIGH + 1, 255)),
                      COLOR_W'($urandom));
        cfg_write(CFG_TINT_LEVEL, pick_tint());
        cfg_release();
    endtask

    task random_phase(input int unsigned count);
        int unsigned burst, i, done;
        done = 0;
        while (done < count) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 20);
            for (i = 0; i < burst && done < count; i++) begin
                send_pixel(pick_level());
                done++;
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 6));
        end
    endtask

    initial begin
        static logic [7:0] reset_pix[5] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd255};
        static logic [7:0] sweep_pix[8] = '{8'd0, 8'd1, 8'd64, 8'd127, 8'd128, 8'd192,
                                            8'd254, 8'd255};
        static logic [7:0] mixed_pix[5] = '{8'd0, 8'd128, 8'd255, 8'd100, 8'd200};
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_pixel_level <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        pixels_sent   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values, incl. negative tint weight at level zero
        foreach (reset_pix[k])
            send_pixel(reset_pix[k]);
        drain();

        // Full tint with extreme colours
        cfg_write(CFG_TINT_LEVEL, 24'hFFFFFF);
        cfg_write(CFG_GRAD_LOW, 24'hFFFFFF);
        cfg_write(CFG_GRAD_MID, 24'h000000);
        cfg_write(CFG_GRAD_HIGH, 24'hFFFFFF);
        cfg_release();
        foreach (sweep_pix[k])
            send_pixel(sweep_pix[k]);
        drain();

        // Writes to unknown indexes must leave the registers alone
        cfg_write(CFG_IDX_W'(CFG_GRAD_HIGH + 1), 24'h000000);
        cfg_write(8'hFF, 24'hFFFFFF);
        cfg_release();
        send_pixel(8'd128);
        send_pixel(8'd255);
        drain();

        // Mid tint with junk above the tint width
        cfg_write(CFG_TINT_LEVEL, 24'h5A5A80);
        cfg_write(CFG_GRAD_LOW, 24'h123456);
        cfg_write(CFG_GRAD_MID, 24'hFEDCBA);
        cfg_write(CFG_GRAD_HIGH, 24'h00FF00);
        cfg_release();
        foreach (mixed_pix[k])
            send_pixel(mixed_pix[k]);
        drain();

        // Random phases, settings changed only while idle
        while (pixels_sent < PIXEL_TARGET) begin
            random_settings();
            random_phase($urandom_range(100, 170));
            drain();
        end

        repeat (LATENCY + 4) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tint_gradient_pixel_map verification clean");
        else
            $display("tint_gradient_pixel_map verification failed");
        $finish;
    end

endmodule
